// File: design/tccs_pkg.sv
// Shared constants, opcodes and controller/datapath interface types for the text console.
package tccs_pkg;

  localparam int COLUMNS     = 80;
  localparam int ROWS        = 25;
  localparam int CELLS       = COLUMNS * ROWS;
  localparam int SHIFT_CELLS = COLUMNS * (ROWS - 1);

  localparam int OP_W   = 2;
  localparam int CHAR_W = 8;
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;

  localparam int ADDR_W = $clog2(CELLS);
  localparam int CNT_W  = $clog2(CELLS + 1);
  localparam int IDX_W  = 14;

  localparam logic [CHAR_W-1:0] BLANK   = 8'h20;
  localparam logic [CHAR_W-1:0] NEWLINE = 8'h0A;
  localparam logic [CHAR_W-1:0] NUL     = 8'h00;

  typedef enum logic [OP_W-1:0] {
    OP_PUT   = 2'd0,
    OP_BACK  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  typedef struct packed {
    logic latch;
    logic exec;
    logic fill_step;
    logic scroll_step;
    logic grab_cell;
    logic load_out;
  } tccs_cmd_t;

  typedef struct packed {
    op_t  op;
    logic put_scroll;
    logic fill_last;
    logic scroll_last;
    logic out_free;
  } tccs_sts_t;

endpackage

// File: design/tccs_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module tccs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: design/tccs_ctrl.sv
// Controller state machine: sequences operations, store sweeps and result hand-off.
module tccs_ctrl import tccs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  tccs_sts_t sts,
  output tccs_cmd_t cmd
);

  typedef enum logic [6:0] {
    S_INIT   = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_OP     = 7'b0000100,
    S_SCROLL = 7'b0001000,
    S_CLEAR  = 7'b0010000,
    S_READ   = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_INIT: begin
        cmd.fill_step = 1'b1;
        if (sts.fill_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_OP;
        end
      end
      S_OP: begin
        cmd.exec = 1'b1;
        unique case (sts.op)
          OP_PUT:   state_nxt = sts.put_scroll ? S_SCROLL : S_DONE;
          OP_BACK:  state_nxt = S_DONE;
          OP_CLEAR: state_nxt = S_CLEAR;
          OP_READ:  state_nxt = S_READ;
          default:  state_nxt = S_DONE;
        endcase
      end
      S_SCROLL: begin
        cmd.scroll_step = 1'b1;
        if (sts.scroll_last) state_nxt = S_DONE;
      end
      S_CLEAR: begin
        cmd.fill_step = 1'b1;
        if (sts.fill_last) state_nxt = S_DONE;
      end
      S_READ: begin
        cmd.grab_cell = 1'b1;
        state_nxt     = S_DONE;
      end
      S_DONE: begin
        // hold until the output register can take the beat
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_INIT;
    endcase
  end

endmodule

// File: design/tccs_dp.sv
// Datapath: item registers, cursor, sweep counter, cell store and result register.
module tccs_dp import tccs_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [OP_W-1:0]   in_opcode,
  input  logic [CHAR_W-1:0] in_char_code,
  input  logic [COL_W-1:0]  in_read_col,
  input  logic [ROW_W-1:0]  in_read_row,
  input  tccs_cmd_t         cmd,
  output tccs_sts_t         sts,
  input  logic              out_stall,
  output logic              out_valid,
  output logic [COL_W-1:0]  out_cursor_col,
  output logic [ROW_W-1:0]  out_cursor_row,
  output logic [CHAR_W-1:0] out_cell_char,
  output logic              out_scrolled
);

  function automatic logic [IDX_W-1:0] cell_idx(logic [COL_W-1:0] col, logic [ROW_W-1:0] row);
    return IDX_W'(row) * IDX_W'(COLUMNS) + IDX_W'(col);
  endfunction

  op_t               op_r;
  logic [CHAR_W-1:0] char_r;
  logic [COL_W-1:0]  rcol_r;
  logic [ROW_W-1:0]  rrow_r;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CHAR_W-1:0] cell_r;
  logic              scrolled_r;
  logic              out_valid_r;
  logic [COL_W-1:0]  out_col_r;
  logic [ROW_W-1:0]  out_row_r;
  logic [CHAR_W-1:0] out_cell_r;
  logic              out_scrolled_r;

  logic [COL_W:0]    col_inc;
  logic              col_wrap, put_nl, put_nul;
  logic [COL_W-1:0]  pcol;
  logic [ROW_W:0]    prow;
  logic              put_scroll;
  logic              bs_noop;
  logic [COL_W-1:0]  bcol;
  logic [ROW_W-1:0]  brow;
  logic [IDX_W-1:0]  put_idx, bs_idx, rd_idx;
  logic              rd_in_range;
  logic              fill_last, scroll_last;

  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [CHAR_W-1:0] ram_wdata, ram_rdata;

  // put: advance, wrap at row end, newline to next row
  assign col_inc  = {1'b0, col_r} + (COL_W+1)'(1);
  assign col_wrap = col_inc >= (COL_W+1)'(COLUMNS);
  assign put_nl   = (char_r == NEWLINE);
  assign put_nul  = (char_r == NUL);

  always_comb begin
    if (put_nl || col_wrap) begin
      pcol = '0;
      prow = {1'b0, row_r} + (ROW_W+1)'(1);
    end else begin
      pcol = col_inc[COL_W-1:0];
      prow = {1'b0, row_r};
    end
  end

  assign put_scroll = (op_r == OP_PUT) && !put_nul && (prow >= (ROW_W+1)'(ROWS - 1));

  // backspace: step back, wrap to last column of previous row
  assign bs_noop = (col_r == '0) && (row_r == '0);
  assign bcol    = (col_r == '0) ? COL_W'(COLUMNS - 1) : col_r - COL_W'(1);
  assign brow    = (col_r == '0) ? row_r - ROW_W'(1) : row_r;

  assign put_idx = cell_idx(col_r, row_r);
  assign bs_idx  = cell_idx(bcol, brow);
  assign rd_idx  = cell_idx(rcol_r, rrow_r);
  assign rd_in_range = ({1'b0, rcol_r} < (COL_W+1)'(COLUMNS)) &&
                       ({1'b0, rrow_r} < (ROW_W+1)'(ROWS));

  assign fill_last   = (cnt_r == CNT_W'(CELLS - 1));
  assign scroll_last = (cnt_r == CNT_W'(SHIFT_CELLS));

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cnt_r[ADDR_W-1:0];
    ram_wdata = BLANK;
    if (cmd.fill_step) begin
      ram_we = 1'b1;
    end else if (cmd.scroll_step) begin
      // the write follows the read in the next cycle: cell n takes the data of cell n+COLUMNS
      ram_we    = (cnt_r != '0);
      ram_waddr = ADDR_W'(cnt_r - CNT_W'(1));
      ram_wdata = ram_rdata;
    end else if (cmd.exec) begin
      case (op_r)
        OP_PUT: begin
          ram_we    = !put_nul && !put_nl;
          ram_waddr = put_idx[ADDR_W-1:0];
          ram_wdata = char_r;
        end
        OP_BACK: begin
          ram_we    = !bs_noop;
          ram_waddr = bs_idx[ADDR_W-1:0];
        end
        default: ram_we = 1'b0;
      endcase
    end
  end

  always_comb begin
    if (cmd.scroll_step) begin
      ram_re    = (cnt_r < CNT_W'(SHIFT_CELLS));
      ram_raddr = ADDR_W'(cnt_r + CNT_W'(COLUMNS));
    end else begin
      ram_re    = rd_in_range;
      ram_raddr = rd_idx[ADDR_W-1:0];
    end
  end

  tccs_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (CELLS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.fill_step) begin
      cnt_nxt = fill_last ? '0 : cnt_r + CNT_W'(1);
    end else if (cmd.scroll_step) begin
      cnt_nxt = scroll_last ? '0 : cnt_r + CNT_W'(1);
    end
  end

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (cmd.exec) begin
      case (op_r)
        OP_PUT: begin
          if (!put_nul) begin
            col_nxt = pcol;
            row_nxt = put_scroll ? ROW_W'(ROWS - 2) : prow[ROW_W-1:0];
          end
        end
        OP_BACK: begin
          if (!bs_noop) begin
            col_nxt = bcol;
            row_nxt = brow;
          end
        end
        default: begin
          col_nxt = col_r;
          row_nxt = row_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      row_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      cnt_r <= cnt_nxt;
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r       <= op_t'(in_opcode);
      char_r     <= in_char_code;
      rcol_r     <= in_read_col;
      rrow_r     <= in_read_row;
      cell_r     <= '0;
      scrolled_r <= 1'b0;
    end
    if (cmd.exec) begin
      scrolled_r <= put_scroll;
    end
    if (cmd.grab_cell) begin
      cell_r <= rd_in_range ? ram_rdata : '0;
    end
    if (cmd.load_out) begin
      out_col_r      <= col_r;
      out_row_r      <= row_r;
      out_cell_r     <= cell_r;
      out_scrolled_r <= scrolled_r;
    end
  end

  assign sts.op          = op_r;
  assign sts.put_scroll  = put_scroll;
  assign sts.fill_last   = fill_last;
  assign sts.scroll_last = scroll_last;
  assign sts.out_free    = !out_valid_r || !out_stall;

  assign out_valid      = out_valid_r;
  assign out_cursor_col = out_col_r;
  assign out_cursor_row = out_row_r;
  assign out_cell_char  = out_cell_r;
  assign out_scrolled   = out_scrolled_r;

endmodule

// File: design/text_console_cursor_scroll_unit.sv
// Top level of the text console: controller plus datapath around the cell store.
// Each item runs from accept to a result beat: put, backspace and put of code 0 execute directly,
// a read grabs the registered cell, a scrolling put sweeps the store up a row, clear fills it.
// One item is in flight; the next is taken once the last is done. One write port sets the sweeps.
// A finished beat waits in the output register while the next item is taken.
// After reset in_stall stays high while the store is filled with spaces.
module text_console_cursor_scroll_unit import tccs_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [OP_W-1:0]   in_opcode,
  input  logic [CHAR_W-1:0] in_char_code,
  input  logic [COL_W-1:0]  in_read_col,
  input  logic [ROW_W-1:0]  in_read_row,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [COL_W-1:0]  out_cursor_col,
  output logic [ROW_W-1:0]  out_cursor_row,
  output logic [CHAR_W-1:0] out_cell_char,
  output logic              out_scrolled
);

  tccs_cmd_t cmd;
  tccs_sts_t sts;

  tccs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  tccs_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_opcode      (in_opcode),
    .in_char_code   (in_char_code),
    .in_read_col    (in_read_col),
    .in_read_row    (in_read_row),
    .cmd            (cmd),
    .sts            (sts),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .out_cursor_col (out_cursor_col),
    .out_cursor_row (out_cursor_row),
    .out_cell_char  (out_cell_char),
    .out_scrolled   (out_scrolled)
  );

endmodule

// File: design/tccs_checker.sv
// Port-level checker for the text console, bound to the top level.
module tccs_checker import tccs_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic [OP_W-1:0]   in_opcode,
  input logic [CHAR_W-1:0] in_char_code,
  input logic [COL_W-1:0]  in_read_col,
  input logic [ROW_W-1:0]  in_read_row,
  input logic              out_valid,
  input logic              out_stall,
  input logic [COL_W-1:0]  out_cursor_col,
  input logic [ROW_W-1:0]  out_cursor_row,
  input logic [CHAR_W-1:0] out_cell_char,
  input logic              out_scrolled
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_cursor_col) &&
    $stable(out_cursor_row) && $stable(out_cell_char) && $stable(out_scrolled))
    else $error("stalled result beat changed");

  // one item at a time: busy right after an accepted beat
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again while an item is in flight");

  // cursor never rests on the last row or past the row end
  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ({1'b0, out_cursor_row} < (ROW_W+1)'(ROWS - 1)) &&
    ({1'b0, out_cursor_col} < (COL_W+1)'(COLUMNS)))
    else $error("cursor out of range");

  // a scroll always leaves the cursor on the second to last row
  a_scroll_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_scrolled |-> out_cursor_row == ROW_W'(ROWS - 2))
    else $error("scroll left cursor on wrong row");

endmodule

bind text_console_cursor_scroll_unit tccs_checker u_tccs_checker (.*);

// File: tb/tb_text_console_cursor_scroll_unit.sv
// Self-checking testbench for the text console: cursor, scroll, backspace, clear and cell reads.
module tb_text_console_cursor_scroll_unit;
  import tccs_pkg::*;

  localparam int HOLD_CYCLES = 400;
  localparam int RANDOM_ITEMS = 300;
  localparam int LIMIT_TIME = 30_000_000;

  class console_tracker;
    logic [COLUMNS-1:0][CHAR_W-1:0] cells [ROWS];
    int cur_col;
    int cur_row;
    logic [COL_W+ROW_W+CHAR_W:0] expected_status [$];
    int error_count;

    function new();
      blank_store();
      cur_col = 0;
      cur_row = 0;
      error_count = 0;
    endfunction

    function void blank_store();
      for (int r = 0; r < ROWS; r++) begin
        for (int c = 0; c < COLUMNS; c++) cells[r][c] = BLANK;
      end
    endfunction

    function int pending();
      return expected_status.size();
    endfunction

    // Apply one accepted command and queue the status beat it must produce.
    function void log_command(op_t op, logic [CHAR_W-1:0] code,
                              logic [COL_W-1:0] rcol, logic [ROW_W-1:0] rrow);
      logic [CHAR_W-1:0] read_char;
      logic scrolled;
      read_char = NUL;
      scrolled = 1'b0;
      case (op)
        OP_PUT: begin
          if (code != NUL) begin
            if (code == NEWLINE) begin
              cur_row++;
              cur_col = 0;
            end else begin
              cells[cur_row][cur_col] = code;
              cur_col++;
              if (cur_col >= COLUMNS) begin
                cur_col = 0;
                cur_row++;
              end
            end
            if (cur_row >= ROWS - 1) begin
              for (int r = 0; r < ROWS - 1; r++) cells[r] = cells[r+1];
              cur_row = ROWS - 2;
              scrolled = 1'b1;
            end
          end
        end
        OP_BACK: begin
          // no effect at the origin
          if (cur_col != 0 || cur_row != 0) begin
            if (cur_col == 0) begin
              cur_row--;
              cur_col = COLUMNS - 1;
            end else begin
              cur_col--;
            end
            cells[cur_row][cur_col] = BLANK;
          end
        end
        OP_CLEAR: blank_store();
        default: begin
          if (rcol < COLUMNS && rrow < ROWS) read_char = cells[rrow][rcol];
        end
      endcase
      expected_status.push_back({COL_W'(cur_col), ROW_W'(cur_row), read_char, scrolled});
    endfunction

    function void flag_mismatch(string field, int want, int got);
      error_count++;
      if (error_count <= 10)
        $display("mismatch on %s: expected %0d, got %0d", field, want, got);
    endfunction

    function void compare_status(logic [COL_W-1:0] col, logic [ROW_W-1:0] row,
                                 logic [CHAR_W-1:0] rd_char, logic scrolled);
      logic [COL_W-1:0] want_col;
      logic [ROW_W-1:0] want_row;
      logic [CHAR_W-1:0] want_char;
      logic want_scrolled;
      if (expected_status.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("status beat with nothing pending: col %0d row %0d char %0d scrolled %0d",
                   col, row, rd_char, scrolled);
        return;
      end
      {want_col, want_row, want_char, want_scrolled} = expected_status.pop_front();
      if (col !== want_col) flag_mismatch("cursor_col", want_col, col);
      if (row !== want_row) flag_mismatch("cursor_row", want_row, row);
      if (rd_char !== want_char) flag_mismatch("cell_char", want_char, rd_char);
      if (scrolled !== want_scrolled) flag_mismatch("scrolled", want_scrolled, scrolled);
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [OP_W-1:0]   in_opcode;
  logic [CHAR_W-1:0] in_char_code;
  logic [COL_W-1:0]  in_read_col;
  logic [ROW_W-1:0]  in_read_row;
  logic              out_valid;
  logic              out_stall;
  logic [COL_W-1:0]  out_cursor_col;
  logic [ROW_W-1:0]  out_cursor_row;
  logic [CHAR_W-1:0] out_cell_char;
  logic              out_scrolled;

  console_tracker tracker;
  int  sent_count;
  int  burst_left;
  logic hold_req;
  logic hold_done;

  text_console_cursor_scroll_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_opcode      (in_opcode),
    .in_char_code   (in_char_code),
    .in_read_col    (in_read_col),
    .in_read_row    (in_read_row),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_cursor_col (out_cursor_col),
    .out_cursor_row (out_cursor_row),
    .out_cell_char  (out_cell_char),
    .out_scrolled   (out_scrolled)
  );

  always #5 clk = ~clk;

  // Sample both channels at the edge, inputs first.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall)
        tracker.log_command(op_t'(in_opcode), in_char_code, in_read_col, in_read_row);
      if (out_valid && !out_stall)
        tracker.compare_status(out_cursor_col, out_cursor_row, out_cell_char, out_scrolled);
    end
  end

  initial begin : status_stall_pattern
    int run_left;
    int mode;
    out_stall = 1'b0;
    hold_done = 1'b0;
    run_left = 0;
    mode = 0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        // hold off long enough for the block to back up into its input
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
        out_stall <= 1'b0;
      end else begin
        if (run_left == 0) begin
          mode = $urandom_range(0, 2);
          run_left = $urandom_range(10, 100);
        end
        run_left--;
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 99) < 30);
          default: out_stall <= ($urandom_range(0, 99) < 75);
        endcase
      end
    end
  end

  initial begin
    #LIMIT_TIME;
    $display("Regression FAIL");
    $finish;
  end

  function automatic logic [CHAR_W-1:0] printable_code();
    logic [CHAR_W-1:0] c;
    do c = CHAR_W'($urandom_range(1, 255)); while (c == NEWLINE);
    return c;
  endfunction

  // Offer one beat, hold it until taken, then maybe open a gap.
  task automatic issue_command(op_t op, int code, int col, int row);
    int gap;
    in_valid     <= 1'b1;
    in_opcode    <= op;
    in_char_code <= CHAR_W'(code);
    in_read_col  <= COL_W'(col);
    in_read_row  <= ROW_W'(row);
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_count++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 40);
      gap = $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (tracker.pending() != 0);
  endtask

  initial begin
    int pick;
    int n;
    bit hold_issued;
    bit mid_drained;
    tracker = new();
    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_opcode = OP_PUT;
    in_char_code = NUL;
    in_read_col = '0;
    in_read_row = '0;
    hold_req = 1'b0;
    sent_count = 0;
    burst_left = 0;
    hold_issued = 1'b0;
    mid_drained = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reads at the edges of the store, origin backspace, NUL,
    // extreme codes, backspace across a row, wrap at the row end, clear.
    issue_command(OP_READ, NUL, 7'd0, 5'd0);
    issue_command(OP_READ, 8'hFF, 7'd127, 5'd31);
    issue_command(OP_READ, NUL, COLUMNS - 1, ROWS - 1);
    issue_command(OP_BACK, 8'hFF, 7'd127, 5'd31);
    issue_command(OP_PUT, NUL, 7'd0, 5'd0);
    issue_command(OP_PUT, 8'hFF, 7'd0, 5'd0);
    issue_command(OP_PUT, 8'h01, 7'd0, 5'd0);
    issue_command(OP_PUT, 8'h41, 7'd0, 5'd0);
    issue_command(OP_READ, NUL, 7'd0, 5'd0);
    issue_command(OP_BACK, NUL, 7'd0, 5'd0);
    issue_command(OP_READ, NUL, 7'd2, 5'd0);
    issue_command(OP_PUT, NEWLINE, 7'd0, 5'd0);
    issue_command(OP_BACK, NUL, 7'd0, 5'd0);
    issue_command(OP_READ, NUL, COLUMNS - 1, 5'd0);
    issue_command(OP_PUT, 8'h7E, 7'd0, 5'd0);
    issue_command(OP_READ, NUL, COLUMNS - 1, 5'd0);
    issue_command(OP_READ, NUL, COLUMNS, 5'd0);
    issue_command(OP_READ, NUL, 7'd0, ROWS);
    issue_command(OP_CLEAR, 8'h55, 7'd42, 5'd21);
    issue_command(OP_READ, NUL, 7'd0, 5'd0);
    issue_command(OP_READ, NUL, 7'd0, 5'd1);
    wait_for_results();

    sent_count = 0;
    while (sent_count < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (!hold_issued && sent_count >= 120) begin
        hold_req <= 1'b1;
        hold_issued = 1'b1;
        burst_left = 16;
        repeat (12)
          issue_command(OP_READ, printable_code(), $urandom_range(0, COLUMNS - 1),
                        $urandom_range(0, ROWS - 1));
      end else if (!mid_drained && sent_count >= 200) begin
        mid_drained = 1'b1;
        wait_for_results();
      end else if (pick < 45) begin
        // a short line of text, then maybe read a cell from the first columns of a random row
        n = $urandom_range(0, 10);
        repeat (n)
          issue_command(OP_PUT, printable_code(), $urandom_range(0, 127),
                        $urandom_range(0, 31));
        issue_command(OP_PUT, NEWLINE, $urandom_range(0, 127), $urandom_range(0, 31));
        if (pick[0])
          issue_command(OP_READ, printable_code(), $urandom_range(0, 11),
                        $urandom_range(0, ROWS - 1));
      end else if (pick < 49) begin
        // run past the row end to force a wrap
        n = COLUMNS + $urandom_range(0, 4);
        repeat (n)
          issue_command(OP_PUT, printable_code(), $urandom_range(0, 127),
                        $urandom_range(0, 31));
      end else if (pick < 59) begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(70, 90) : $urandom_range(1, 5);
        repeat (n)
          issue_command(OP_BACK, $urandom_range(0, 255), $urandom_range(0, 127),
                        $urandom_range(0, 31));
      end else if (pick < 79) begin
        n = $urandom_range(1, 4);
        repeat (n) begin
          if ($urandom_range(0, 5) == 0)
            issue_command(OP_READ, $urandom_range(0, 255), $urandom_range(0, 127),
                          $urandom_range(0, 31));
          else
            issue_command(OP_READ, $urandom_range(0, 255), $urandom_range(0, COLUMNS - 1),
                          $urandom_range(0, ROWS - 1));
        end
      end else if (pick < 83) begin
        issue_command(OP_CLEAR, $urandom_range(0, 255), $urandom_range(0, 127),
                      $urandom_range(0, 31));
      end else begin
        issue_command(op_t'($urandom_range(0, 3)), $urandom_range(0, 255),
                      $urandom_range(0, 127), $urandom_range(0, 31));
      end
    end

    wait_for_results();
    repeat (20) @(posedge clk);
    if (tracker.error_count == 0 && tracker.pending() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
